/* sv/assert_macros.svh */
// Assertion macros shared by the polygon area and convexity block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define PAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`define PAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define PAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define PAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/pac_pkg.sv */
// Types and constants shared by the polygon area and convexity block.
`default_nettype none

package pac_pkg;

  localparam int AREA_W = 44;
  localparam int OUT_W  = 42;

  localparam int X_E1  = 0;
  localparam int X_T1  = 1;
  localparam int X_E2  = 2;
  localparam int X_T2  = 3;
  localparam int X_T3  = 4;
  localparam int NUM_X = 5;

  localparam int NUM_T = 3;

  typedef logic signed [AREA_W-1:0] area_t;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    logic last;
    logic e1_en;
    logic t1_en;
    logic t23_en;
    logic ovf;
  } ctl_t;

  typedef struct packed {
    area_t sum;
    logic  convex;
    logic  ovf;
  } fin_t;

endpackage

`default_nettype wire

/* sv/pac_cross.sv */
// Input register, vertex tracking and cross-product multiplier stage.
`default_nettype none
`include "assert_macros.svh"

module pac_cross #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_vx,
  input  wire logic signed [COORD_BITS-1:0] in_vy,
  input  wire logic                         in_last_vertex,
  output      logic                         valid_o,
  output      logic signed [PW-1:0]         pa_o [pac_pkg::NUM_X],
  output      logic signed [PW-1:0]         pb_o [pac_pkg::NUM_X],
  output      pac_pkg::ctl_t                ctl_o,
  input  wire logic                         take_i
);

  localparam int CW = $clog2(MAX_VERTICES + 2);
  localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);

  logic                         s1_valid_r;
  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic                         last_r;
  logic [CW-1:0]                count_r;
  logic signed [COORD_BITS-1:0] fx_r, fy_r, sx_r, sy_r, ox_r, oy_r, rx_r, ry_r;
  logic                         s2_valid_r;
  logic signed [PW-1:0]         pa_r [pac_pkg::NUM_X];
  logic signed [PW-1:0]         pb_r [pac_pkg::NUM_X];
  pac_pkg::ctl_t                ctl_r;

  logic                         s2_free, s1_move;
  logic                         proc, first_v, second_v, past2, ovf, nge3;
  logic [CW-1:0]                cnt_inc, nfin, count_nxt;
  logic signed [COORD_BITS-1:0] fpx_nxt, fpy_nxt, spx_nxt, spy_nxt;
  logic signed [COORD_BITS-1:0] opx_nxt, opy_nxt, rpx_nxt, rpy_nxt;
  logic signed [DW-1:0]         nx, ny, ox, oy, rx, ry;
  logic signed [DW-1:0]         fpx, fpy, spx, spy, opx, opy, rpx, rpy;
  logic signed [PW-1:0]         pa_nxt [pac_pkg::NUM_X];
  logic signed [PW-1:0]         pb_nxt [pac_pkg::NUM_X];
  pac_pkg::ctl_t                ctl_nxt;

  assign s2_free  = !s2_valid_r || take_i;
  assign s1_move  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  always_comb begin
    proc     = count_r < MAXV;
    first_v  = count_r == '0;
    second_v = count_r == CW'(1);
    past2    = count_r >= CW'(2);
    cnt_inc  = (count_r <= MAXV) ? count_r + CW'(1) : count_r;
    ovf      = cnt_inc > MAXV;
    nfin     = ovf ? MAXV : cnt_inc;
    nge3     = nfin >= CW'(3);
    count_nxt = last_r ? '0 : cnt_inc;

    fpx_nxt = (proc && first_v)  ? x_r : fx_r;
    fpy_nxt = (proc && first_v)  ? y_r : fy_r;
    spx_nxt = (proc && second_v) ? x_r : sx_r;
    spy_nxt = (proc && second_v) ? y_r : sy_r;
    opx_nxt = proc ? rx_r : ox_r;
    opy_nxt = proc ? ry_r : oy_r;
    rpx_nxt = proc ? x_r  : rx_r;
    rpy_nxt = proc ? y_r  : ry_r;

    nx  = DW'(x_r);
    ny  = DW'(y_r);
    ox  = DW'(ox_r);
    oy  = DW'(oy_r);
    rx  = DW'(rx_r);
    ry  = DW'(ry_r);
    fpx = DW'(fpx_nxt);
    fpy = DW'(fpy_nxt);
    spx = DW'(spx_nxt);
    spy = DW'(spy_nxt);
    opx = DW'(opx_nxt);
    opy = DW'(opy_nxt);
    rpx = DW'(rpx_nxt);
    rpy = DW'(rpy_nxt);

    pa_nxt[pac_pkg::X_E1] = rx * ny;
    pb_nxt[pac_pkg::X_E1] = ry * nx;
    pa_nxt[pac_pkg::X_T1] = DW'(rx - ox) * DW'(ny - oy);
    pb_nxt[pac_pkg::X_T1] = DW'(ry - oy) * DW'(nx - ox);
    pa_nxt[pac_pkg::X_E2] = rpx * fpy;
    pb_nxt[pac_pkg::X_E2] = rpy * fpx;
    pa_nxt[pac_pkg::X_T2] = DW'(rpx - opx) * DW'(fpy - opy);
    pb_nxt[pac_pkg::X_T2] = DW'(rpy - opy) * DW'(fpx - opx);
    pa_nxt[pac_pkg::X_T3] = DW'(fpx - rpx) * DW'(spy - rpy);
    pb_nxt[pac_pkg::X_T3] = DW'(fpy - rpy) * DW'(spx - rpx);

    ctl_nxt.last   = last_r;
    ctl_nxt.e1_en  = proc && !first_v;
    ctl_nxt.t1_en  = proc && past2;
    ctl_nxt.t23_en = last_r && nge3;
    ctl_nxt.ovf    = ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r    <= in_vx;
      y_r    <= in_vy;
      last_r <= in_last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (s1_move) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      fx_r <= fpx_nxt;
      fy_r <= fpy_nxt;
      sx_r <= spx_nxt;
      sy_r <= spy_nxt;
      ox_r <= opx_nxt;
      oy_r <= opy_nxt;
      rx_r <= rpx_nxt;
      ry_r <= rpy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign valid_o = s2_valid_r;
  assign pa_o    = pa_r;
  assign pb_o    = pb_r;
  assign ctl_o   = ctl_r;

  `PAC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= MAXV + CW'(1))
  `PAC_ASSERT_NEXT(a_count_clear, clk, rst_n, s1_move && last_r, count_r == '0)

endmodule

`default_nettype wire

/* sv/pac_accum.sv */
// Cross-term and turn-sign stage, shoelace accumulator and final-result register.
`default_nettype none
`include "assert_macros.svh"

module pac_accum #(
  parameter int COORD_BITS = 16,
  localparam int PW = 2 * (COORD_BITS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 valid_i,
  input  wire logic signed [PW-1:0] pa_i [pac_pkg::NUM_X],
  input  wire logic signed [PW-1:0] pb_i [pac_pkg::NUM_X],
  input  wire pac_pkg::ctl_t        ctl_i,
  output      logic                 take_o,
  output      logic                 fin_valid_o,
  output      pac_pkg::fin_t        fin_o,
  input  wire logic                 fin_take_i
);

  function automatic pac_pkg::sign_t turn_of(input logic signed [PW-1:0] a,
                                             input logic signed [PW-1:0] b);
    pac_pkg::sign_t s;
    if (a > b) begin
      s = pac_pkg::SIGN_POS;
    end else if (a < b) begin
      s = pac_pkg::SIGN_NEG;
    end else begin
      s = pac_pkg::SIGN_NONE;
    end
    return s;
  endfunction

  logic           s3_valid_r;
  pac_pkg::area_t e1_r, e2_r;
  pac_pkg::sign_t sg_r [pac_pkg::NUM_T];
  logic           last3_r, ovf3_r;
  pac_pkg::area_t area_r;
  pac_pkg::sign_t turn_r;
  logic           nc_r;
  logic           fin_valid_r;
  pac_pkg::fin_t  fin_r;

  logic             fin_free, s3_move;
  logic signed [PW:0] de1, de2;
  pac_pkg::area_t   e1_nxt, e2_nxt, sum;
  pac_pkg::sign_t   sg_nxt [pac_pkg::NUM_T];
  pac_pkg::sign_t   turn_nxt;
  logic             nc_nxt;

  assign fin_free = !fin_valid_r || fin_take_i;
  assign s3_move  = s3_valid_r && fin_free;
  assign take_o   = !s3_valid_r || fin_free;

  always_comb begin
    de1 = (PW+1)'(pa_i[pac_pkg::X_E1]) - (PW+1)'(pb_i[pac_pkg::X_E1]);
    de2 = (PW+1)'(pa_i[pac_pkg::X_E2]) - (PW+1)'(pb_i[pac_pkg::X_E2]);
    e1_nxt = ctl_i.e1_en ? pac_pkg::area_t'(de1) : '0;
    e2_nxt = ctl_i.last  ? pac_pkg::area_t'(de2) : '0;
    sg_nxt[0] = ctl_i.t1_en ?
                turn_of(pa_i[pac_pkg::X_T1], pb_i[pac_pkg::X_T1]) : pac_pkg::SIGN_NONE;
    sg_nxt[1] = ctl_i.t23_en ?
                turn_of(pa_i[pac_pkg::X_T2], pb_i[pac_pkg::X_T2]) : pac_pkg::SIGN_NONE;
    sg_nxt[2] = ctl_i.t23_en ?
                turn_of(pa_i[pac_pkg::X_T3], pb_i[pac_pkg::X_T3]) : pac_pkg::SIGN_NONE;
  end

  always_comb begin
    sum      = area_r + e1_r + e2_r;
    turn_nxt = turn_r;
    nc_nxt   = nc_r;
    for (int i = 0; i < pac_pkg::NUM_T; i++) begin
      if (sg_r[i] != pac_pkg::SIGN_NONE) begin
        if (turn_nxt == pac_pkg::SIGN_NONE) begin
          turn_nxt = sg_r[i];
        end else if (turn_nxt != sg_r[i]) begin
          nc_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (take_o) begin
      s3_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && take_o) begin
      e1_r    <= e1_nxt;
      e2_r    <= e2_nxt;
      sg_r    <= sg_nxt;
      last3_r <= ctl_i.last;
      ovf3_r  <= ctl_i.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= '0;
      turn_r <= pac_pkg::SIGN_NONE;
      nc_r   <= 1'b0;
    end else if (s3_move) begin
      if (last3_r) begin
        area_r <= '0;
        turn_r <= pac_pkg::SIGN_NONE;
        nc_r   <= 1'b0;
      end else begin
        area_r <= sum;
        turn_r <= turn_nxt;
        nc_r   <= nc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (s3_move && last3_r) begin
      fin_valid_r <= 1'b1;
    end else if (fin_take_i) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move && last3_r) begin
      fin_r.sum    <= sum;
      fin_r.convex <= !nc_nxt;
      fin_r.ovf    <= ovf3_r;
    end
  end

  assign fin_valid_o = fin_valid_r;
  assign fin_o       = fin_r;

  `PAC_ASSERT_NEXT(a_fin_hold, clk, rst_n, fin_valid_r && !fin_take_i,
                   fin_valid_r && $stable(fin_r))
  `PAC_ASSERT_NEXT(a_state_clear, clk, rst_n, s3_move && last3_r,
                   area_r == '0 && turn_r == pac_pkg::SIGN_NONE && !nc_r)

endmodule

`default_nettype wire

/* sv/pac_out.sv */
// Magnitude of the shoelace sum and the result output register.
`default_nettype none
`include "assert_macros.svh"

module pac_out (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fin_valid_i,
  input  wire pac_pkg::fin_t             fin_i,
  output      logic                      fin_take_o,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [pac_pkg::OUT_W-1:0] out_twice_area,
  output      logic                      out_is_convex,
  output      logic                      out_overflow
);

  logic                      out_valid_r;
  logic [pac_pkg::OUT_W-1:0] area_r;
  logic                      convex_r, ovf_r;
  pac_pkg::area_t            mag;

  assign fin_take_o = !out_valid_r || out_ready;

  always_comb begin
    mag = fin_i.sum[pac_pkg::AREA_W-1] ? (~fin_i.sum + pac_pkg::area_t'(1)) : fin_i.sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_take_o) begin
      out_valid_r <= fin_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid_i && fin_take_o) begin
      area_r   <= mag[pac_pkg::OUT_W-1:0];
      convex_r <= fin_i.convex;
      ovf_r    <= fin_i.ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_twice_area = area_r;
  assign out_is_convex  = convex_r;
  assign out_overflow   = ovf_r;

  `PAC_ASSERT_NEXT(a_fin_to_out, clk, rst_n, fin_valid_i && fin_take_o, out_valid_r)

endmodule

`default_nettype wire

/* sv/polygon_area_convexity.sv */
// Top level of the streaming polygon area and convexity unit.
// Input channel: one vertex per transaction (in_vx, in_vy signed, in_last_vertex
// marks the closing vertex of a polygon), handshaked by in_valid and in_ready.
// Result channel: one transaction per polygon, presented by out_valid with
// out_twice_area (absolute shoelace sum), out_is_convex and out_overflow.
// Throughput: one vertex per cycle while out_ready does not stall the pipeline.
// The result of a polygon passes through the input register, multiplier register,
// cross-term register, accumulator result register and output register after
// its closing vertex is accepted.
// Polygons follow one another with no gap; accumulator state clears itself
// when the closing vertex passes the accumulator.
// Reset (rst_n low, synchronous) empties every stage and clears the vertex
// count and the accumulators; no result is pending afterwards.
// A stalled receiver holds the result; the stages behind it fill and then
// in_ready drops until out_ready frees the output register.
// Vertices beyond MAX_VERTICES are counted but dropped; they set out_overflow.
`default_nettype none

module polygon_area_convexity #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_vx,
  input  wire logic signed [COORD_BITS-1:0] in_vy,
  input  wire logic                         in_last_vertex,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [pac_pkg::OUT_W-1:0]    out_twice_area,
  output      logic                         out_is_convex,
  output      logic                         out_overflow
);

  localparam int PW = 2 * (COORD_BITS + 1);

  logic                 prod_valid;
  logic signed [PW-1:0] prod_a [pac_pkg::NUM_X];
  logic signed [PW-1:0] prod_b [pac_pkg::NUM_X];
  pac_pkg::ctl_t        prod_ctl;
  logic                 prod_take;
  logic                 fin_valid;
  pac_pkg::fin_t        fin;
  logic                 fin_take;

  pac_cross #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_cross (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vx          (in_vx),
    .in_vy          (in_vy),
    .in_last_vertex (in_last_vertex),
    .valid_o        (prod_valid),
    .pa_o           (prod_a),
    .pb_o           (prod_b),
    .ctl_o          (prod_ctl),
    .take_i         (prod_take)
  );

  pac_accum #(
    .COORD_BITS (COORD_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (prod_valid),
    .pa_i        (prod_a),
    .pb_i        (prod_b),
    .ctl_i       (prod_ctl),
    .take_o      (prod_take),
    .fin_valid_o (fin_valid),
    .fin_o       (fin),
    .fin_take_i  (fin_take)
  );

  pac_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .fin_valid_i    (fin_valid),
    .fin_i          (fin),
    .fin_take_o     (fin_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_twice_area (out_twice_area),
    .out_is_convex  (out_is_convex),
    .out_overflow   (out_overflow)
  );

endmodule

`default_nettype wire

/* verif/tb_polygon_area_convexity.sv */
// Self-checking testbench for the streaming polygon area and convexity unit.
module tb_polygon_area_convexity;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERTS = 1024;
  localparam int CW        = 16;

  typedef struct {
    logic [pac_pkg::OUT_W-1:0] twice_area;
    logic                      is_convex;
    logic                      overflow;
  } poly_result_t;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_ready;
  logic signed [CW-1:0]      in_vx          = '0;
  logic signed [CW-1:0]      in_vy          = '0;
  logic                      in_last_vertex = 1'b0;
  logic                      out_valid;
  logic                      out_ready      = 1'b0;
  logic [pac_pkg::OUT_W-1:0] out_twice_area;
  logic                      out_is_convex;
  logic                      out_overflow;

  // Predicted state of the polygon in flight.
  logic signed [CW-1:0] start_x, start_y, next_x, next_y;
  logic signed [CW-1:0] prev_x, prev_y, cur_x, cur_y;
  pac_pkg::area_t       shoelace_sum;
  pac_pkg::sign_t       turn_dir;
  logic                 bent;
  int unsigned          vert_count;

  poly_result_t expected_polys[$];
  poly_result_t check_want;
  int unsigned  fail_count = 0;

  bit           tx_idle_en = 1'b1;
  logic         rx_idle_en = 1'b1;
  logic         rx_hold    = 1'b0;
  int unsigned  rx_wait;
  int unsigned  rx_draw;

  polygon_area_convexity dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vx          (in_vx),
    .in_vy          (in_vy),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_twice_area (out_twice_area),
    .out_is_convex  (out_is_convex),
    .out_overflow   (out_overflow)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (fail_count < 100) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic void add_shoelace(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                       input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by);
    longint t;
    t = longint'(ax) * by - longint'(ay) * bx;
    shoelace_sum = shoelace_sum + t[pac_pkg::AREA_W-1:0];
  endfunction

  function automatic void add_turn(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                   input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                                   input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy);
    longint         c;
    pac_pkg::sign_t s;
    c = (longint'(bx) - ax) * (longint'(cy) - ay) - (longint'(by) - ay) * (longint'(cx) - ax);
    if (c != 0) begin
      s = (c > 0) ? pac_pkg::SIGN_POS : pac_pkg::SIGN_NEG;
      if (turn_dir == pac_pkg::SIGN_NONE) begin
        turn_dir = s;
      end else if (turn_dir != s) begin
        bent = 1'b1;
      end
    end
  endfunction

  function automatic void absorb_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                        input logic last);
    int unsigned    n;
    logic           ovf;
    pac_pkg::area_t mag;
    poly_result_t   res;
    if (vert_count < MAX_VERTS) begin
      if (vert_count == 0) begin
        start_x = x;
        start_y = y;
      end else begin
        add_shoelace(cur_x, cur_y, x, y);
      end
      if (vert_count == 1) begin
        next_x = x;
        next_y = y;
      end
      if (vert_count >= 2) begin
        add_turn(prev_x, prev_y, cur_x, cur_y, x, y);
      end
      prev_x = cur_x;
      prev_y = cur_y;
      cur_x  = x;
      cur_y  = y;
      vert_count++;
    end else if (vert_count == MAX_VERTS) begin
      vert_count++;
    end
    if (last) begin
      ovf = vert_count > MAX_VERTS;
      n   = ovf ? MAX_VERTS : vert_count;
      add_shoelace(cur_x, cur_y, start_x, start_y);
      if (n >= 3) begin
        add_turn(prev_x, prev_y, cur_x, cur_y, start_x, start_y);
        add_turn(cur_x, cur_y, start_x, start_y, next_x, next_y);
      end
      mag = shoelace_sum[pac_pkg::AREA_W-1] ? -shoelace_sum : shoelace_sum;
      res.twice_area = mag[pac_pkg::OUT_W-1:0];
      res.is_convex  = (n < 3) || !bent;
      res.overflow   = ovf;
      expected_polys.push_back(res);
      start_x = '0; start_y = '0; next_x = '0; next_y = '0;
      prev_x  = '0; prev_y  = '0; cur_x  = '0; cur_y  = '0;
      shoelace_sum = '0;
      turn_dir     = pac_pkg::SIGN_NONE;
      bent         = 1'b0;
      vert_count   = 0;
    end
  endfunction

  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic last);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_vx          <= x;
    in_vy          <= y;
    in_last_vertex <= last;
    do @(posedge clk); while (!in_ready);
    absorb_vertex(x, y, last);
  endtask

  // Points on a circle at increasing angles (decreasing when clockwise); dent_at pulls one vertex inward.
  task automatic send_ring(input int n, input int radius, input int cx, input int cy,
                           input bit clockwise, input int dent_at);
    real step;
    real ang;
    int  r;
    int  k;
    step = 6.283185307179586 / n;
    for (k = 0; k < n; k++) begin
      ang = (k + 0.8 * ($urandom_range(0, 1000) / 1000.0)) * step;
      if (clockwise) ang = -ang;
      r = (k == dent_at) ? radius / 3 : radius;
      send_vertex(CW'(cx + int'(r * $cos(ang))), CW'(cy + int'(r * $sin(ang))), k == n - 1);
    end
  endtask

  task automatic send_random_ring(input int n, input int dent_at);
    int radius;
    int span;
    radius = $urandom_range(1, 32000);
    span   = 32767 - radius;
    send_ring(n, radius, int'($urandom_range(0, 2 * span)) - span,
              int'($urandom_range(0, 2 * span)) - span, $urandom_range(0, 1), dent_at);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_polys.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // single vertex and two vertices
    send_vertex(16'sd5, -16'sd7, 1'b1);
    send_vertex(-16'sd32768, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b1);
    // a square, then a clockwise triangle at the coordinate extremes
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b0);
    send_vertex(16'sd0, 16'sd10, 1'b1);
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b1);
    // all collinear
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1, 16'sd1, 1'b0);
    send_vertex(16'sd2, 16'sd2, 1'b1);
    // concave arrow
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd4, 16'sd2, 1'b0);
    send_vertex(16'sd0, 16'sd4, 1'b0);
    send_vertex(16'sd1, 16'sd2, 1'b1);
    // collinear midpoint on an edge, then a wide triangle
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd2, 16'sd0, 1'b0);
    send_vertex(16'sd4, 16'sd0, 1'b0);
    send_vertex(16'sd2, 16'sd3, 1'b1);
    send_vertex(-16'sd1, -16'sd1, 1'b0);
    send_vertex(16'sd32767, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd32767, 1'b1);
    drain_results();
  endtask

  task automatic test_vertex_limit();
    send_ring(MAX_VERTS + 1, 25000, -500, 700, 1'b0, 17);
    drain_results();
  endtask

  task automatic test_output_stall();
    int i;
    tx_idle_en = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (250) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        for (i = 0; i < 12; i++) begin
          send_random_ring(3, -1);
        end
      end
    join
    drain_results();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_polygons();
    int unsigned sent;
    int unsigned polys;
    int unsigned kind;
    int unsigned mode;
    int          n;
    int          k;
    sent  = 0;
    polys = 0;
    while (sent < 60) begin
      if (polys % 3 == 0) begin
        mode       = $urandom_range(0, 3);
        tx_idle_en = mode[0];
        rx_idle_en <= mode[1];
      end
      if (polys % 4 == 3) drain_results();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        n = $urandom_range(3, 12);
        send_random_ring(n, -1);
      end else if (kind < 65) begin
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) send_vertex(CW'($urandom), CW'($urandom), k == n - 1);
      end else if (kind < 80) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          send_vertex(CW'(int'($urandom_range(0, 6)) - 3), CW'(int'($urandom_range(0, 6)) - 3),
                      k == n - 1);
        end
      end else if (kind < 90) begin
        n = $urandom_range(1, 2);
        for (k = 0; k < n; k++) send_vertex(CW'($urandom), CW'($urandom), k == n - 1);
      end else begin
        n = $urandom_range(4, 12);
        send_random_ring(n, $urandom_range(0, n - 1));
      end
      sent += n;
      polys++;
    end
    drain_results();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_draw = rx_idle_en ? $urandom_range(0, 15) : 0;
      rx_wait   <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_polys.size() == 0) begin
        report_mismatch("result transaction with none expected");
      end else begin
        check_want = expected_polys.pop_front();
        if (out_twice_area !== check_want.twice_area) begin
          report_mismatch($sformatf("twice_area got %0d want %0d",
                                    out_twice_area, check_want.twice_area));
        end
        if (out_is_convex !== check_want.is_convex) begin
          report_mismatch($sformatf("is_convex got %b want %b",
                                    out_is_convex, check_want.is_convex));
        end
        if (out_overflow !== check_want.overflow) begin
          report_mismatch($sformatf("overflow got %b want %b",
                                    out_overflow, check_want.overflow));
        end
      end
    end
  end

  initial begin
    start_x = '0; start_y = '0; next_x = '0; next_y = '0;
    prev_x  = '0; prev_y  = '0; cur_x  = '0; cur_y  = '0;
    shoelace_sum = '0;
    turn_dir     = pac_pkg::SIGN_NONE;
    bent         = 1'b0;
    vert_count   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_vertex_limit();
    test_output_stall();
    test_random_polygons();
    repeat (20) @(posedge clk);
    if (expected_polys.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_polys.size()));
    end
    if (fail_count == 0) begin
      $display("tb_polygon_area_convexity OK");
    end else begin
      $display("tb_polygon_area_convexity NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_polygon_area_convexity NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/pac_pkg.sv
sv/pac_cross.sv
sv/pac_accum.sv
sv/pac_out.sv
sv/polygon_area_convexity.sv
verif/tb_polygon_area_convexity.sv
